// ----- hw/rtl/cpr_pkg.sv -----
`timescale 1ns / 1ps
package cpr_pkg;

	localparam int SQ_STEPS  = 34;
	localparam int DIV_STEPS = 32;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		word_t [2:0] pt;
		word_t [2:0] anc;
		logic  [2:0] neg;
		logic        clamp;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [2:0][63:0] prod;
		logic [67:0]      n;
		logic [34:0]      rem;
		logic [33:0]      root;
	} sq_t;

	typedef struct packed {
		side_t            side;
		logic [33:0]      len;
		logic [2:0][33:0] rem;
		logic [2:0][31:0] num;
		logic [2:0][31:0] q;
	} dv_t;

endpackage

// ----- hw/rtl/clamp_point_to_radius.sv -----
`timescale 1ns / 1ps
// clamp_point_to_radius: pulls a target point back to within max_radius of an anchor.
// input channel: in_valid / in_ready carry one word of six signed Q16.16 coordinates
// (point and anchor). output channel: out_valid / out_ready carry the resulting point
// and the was_clamped flag, one output word per input word, in order.
// max_radius is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, the block itself does not enforce this. the pipeline has
// three front stages (difference, squares and products, sum and compare), 34 square
// root cells, one divider setup stage, 32 divider cells and the output register.
// throughput is one word per cycle, a new word taken every cycle while the output moves.
// when the receiver stalls with a word waiting, the whole pipeline holds and in_ready
// drops; it rises again in the cycle the waiting word is taken.
// reset clears all valid bits, so no output word appears, and loads max_radius with 2.0.
module clamp_point_to_radius (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cpr_pkg::word_t point_x,
	input  cpr_pkg::word_t point_y,
	input  cpr_pkg::word_t point_z,
	input  cpr_pkg::word_t anchor_x,
	input  cpr_pkg::word_t anchor_y,
	input  cpr_pkg::word_t anchor_z,
	output logic           out_valid,
	input  logic           out_ready,
	output cpr_pkg::word_t out_x,
	output cpr_pkg::word_t out_y,
	output cpr_pkg::word_t out_z,
	output logic           was_clamped,
	input  logic           cfg_wr_en,
	input  logic [30:0]    cfg_wr_data
);
	logic [30:0]  max_radius_q;
	logic         en;
	cpr_pkg::sq_t sq_d [0:cpr_pkg::SQ_STEPS];
	logic         sq_v [0:cpr_pkg::SQ_STEPS];
	cpr_pkg::dv_t dv_d [0:cpr_pkg::DIV_STEPS];
	logic         dv_v [0:cpr_pkg::DIV_STEPS];
	logic [2:0][63:0]       num;
	logic [2:0][32:0]       off;
	logic [2:0][33:0]       tot;
	cpr_pkg::word_t [2:0]   res;
	cpr_pkg::dv_t           dl;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_radius_q <= 31'd131072;
		else if (cfg_wr_en)
			max_radius_q <= cfg_wr_data;
	end

	cpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_i    (in_valid && in_ready),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.anchor_x (anchor_x),
		.anchor_y (anchor_y),
		.anchor_z (anchor_z),
		.rad_i    (max_radius_q),
		.vld_o    (sq_v[0]),
		.d_o      (sq_d[0])
	);

	for (genvar k = 0; k < cpr_pkg::SQ_STEPS; k++) begin : g_sqrt
		cpr_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sq_v[k]),
			.d_i    (sq_d[k]),
			.vld_o  (sq_v[k+1]),
			.d_o    (sq_d[k+1])
		);
	end

	// divider setup: numerator is mag * radius plus half the length for rounding
	always_comb begin
		for (int j = 0; j < 3; j++)
			num[j] = sq_d[cpr_pkg::SQ_STEPS].prod[j]
				+ 64'(sq_d[cpr_pkg::SQ_STEPS].root[33:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v[0] <= 1'b0;
		else if (en)
			dv_v[0] <= sq_v[cpr_pkg::SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d[0].side <= sq_d[cpr_pkg::SQ_STEPS].side;
			dv_d[0].len  <= sq_d[cpr_pkg::SQ_STEPS].root;
			for (int j = 0; j < 3; j++) begin
				dv_d[0].rem[j] <= {2'b00, num[j][63:32]};
				dv_d[0].num[j] <= num[j][31:0];
				dv_d[0].q[j]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < cpr_pkg::DIV_STEPS; k++) begin : g_div
		cpr_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv_v[k]),
			.d_i    (dv_d[k]),
			.vld_o  (dv_v[k+1]),
			.d_o    (dv_d[k+1])
		);
	end

	// offset sign, anchor add and saturation
	always_comb begin
		dl = dv_d[cpr_pkg::DIV_STEPS];
		for (int j = 0; j < 3; j++) begin
			off[j] = dl.side.neg[j] ? 33'(-{1'b0, dl.q[j]}) : {1'b0, dl.q[j]};
			tot[j] = {{2{dl.side.anc[j][31]}}, dl.side.anc[j]} + {off[j][32], off[j]};
			if (!dl.side.clamp)
				res[j] = dl.side.pt[j];
			else if (!tot[j][33] && tot[j][32:31] != 2'b00)
				res[j] = 32'sh7FFFFFFF;
			else if (tot[j][33] && tot[j][32:31] != 2'b11)
				res[j] = 32'sh80000000;
			else
				res[j] = tot[j][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= dv_v[cpr_pkg::DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x       <= res[0];
			out_y       <= res[1];
			out_z       <= res[2];
			was_clamped <= dl.side.clamp;
		end
	end
endmodule

// ----- hw/rtl/cpr_front.sv -----
`timescale 1ns / 1ps
module cpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  cpr_pkg::word_t    point_x,
	input  cpr_pkg::word_t    point_y,
	input  cpr_pkg::word_t    point_z,
	input  cpr_pkg::word_t    anchor_x,
	input  cpr_pkg::word_t    anchor_y,
	input  cpr_pkg::word_t    anchor_z,
	input  logic [30:0]       rad_i,
	output logic              vld_o,
	output cpr_pkg::sq_t      d_o
);
	logic              v_s1, v_s2;
	cpr_pkg::side_t    side_s1, side_s2;
	cpr_pkg::side_t    side_c;
	logic [2:0][31:0]  mag_s1;
	logic [30:0]       rad_s1;
	logic [2:0][63:0]  sq_s2;
	logic [2:0][62:0]  prod_s2;
	logic [61:0]       r2_s2;
	cpr_pkg::word_t [2:0] pt_w, anc_w;
	logic [2:0][32:0]  dif;
	logic [2:0][32:0]  neg_dif;
	logic [65:0]       sum;

	assign pt_w  = {point_z, point_y, point_x};
	assign anc_w = {anchor_z, anchor_y, anchor_x};

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dif[j]     = {pt_w[j][31], pt_w[j]} - {anc_w[j][31], anc_w[j]};
			neg_dif[j] = 33'(-dif[j]);
		end
		sum = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
		side_c       = side_s2;
		side_c.clamp = sum > 66'(r2_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			v_s1  <= vld_i;
			v_s2  <= v_s1;
			vld_o <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.pt    <= pt_w;
			side_s1.anc   <= anc_w;
			side_s1.clamp <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				side_s1.neg[j] <= dif[j][32];
				mag_s1[j]      <= dif[j][32] ? neg_dif[j][31:0] : dif[j][31:0];
			end
			rad_s1 <= rad_i;

			side_s2 <= side_s1;
			for (int j = 0; j < 3; j++) begin
				sq_s2[j]   <= mag_s1[j] * mag_s1[j];
				prod_s2[j] <= mag_s1[j] * rad_s1;
			end
			r2_s2 <= rad_s1 * rad_s1;

			d_o.side <= side_c;
			for (int j = 0; j < 3; j++)
				d_o.prod[j] <= 64'(prod_s2[j]);
			d_o.n    <= 68'(sum);
			d_o.rem  <= '0;
			d_o.root <= '0;
		end
	end
endmodule

// ----- hw/rtl/cpr_sqrt_cell.sv -----
`timescale 1ns / 1ps
module cpr_sqrt_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_i,
	input  cpr_pkg::sq_t d_i,
	output logic         vld_o,
	output cpr_pkg::sq_t d_o
);
	logic [36:0] cur;
	logic [36:0] trial;
	logic        ge;

	always_comb begin
		cur   = {d_i.rem, d_i.n[67:66]};
		trial = {1'b0, d_i.root, 2'b01};
		ge    = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.side <= d_i.side;
			d_o.prod <= d_i.prod;
			d_o.n    <= {d_i.n[65:0], 2'b00};
			d_o.rem  <= ge ? 35'(cur - trial) : cur[34:0];
			d_o.root <= {d_i.root[32:0], ge};
		end
	end
endmodule

// ----- hw/rtl/cpr_div_cell.sv -----
`timescale 1ns / 1ps
module cpr_div_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_i,
	input  cpr_pkg::dv_t d_i,
	output logic         vld_o,
	output cpr_pkg::dv_t d_o
);
	logic [2:0][34:0] cur;
	logic [2:0]       ge;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cur[j] = {d_i.rem[j], d_i.num[j][31]};
			ge[j]  = cur[j] >= {1'b0, d_i.len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.side <= d_i.side;
			d_o.len  <= d_i.len;
			for (int j = 0; j < 3; j++) begin
				d_o.rem[j] <= ge[j] ? 34'(cur[j] - {1'b0, d_i.len}) : cur[j][33:0];
				d_o.num[j] <= {d_i.num[j][30:0], 1'b0};
				d_o.q[j]   <= {d_i.q[j][30:0], ge[j]};
			end
		end
	end
endmodule
